FILE: src/urss_pkg.sv
// Shared types, constants and the segment table of the ultrasonic range display unit.
package urss_pkg;

    localparam int DIGITS    = 4;
    localparam int POS_W     = $clog2(DIGITS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [9:0] NO_ECHO_CM = 10'd999;
    localparam logic [3:0] DASH_CODE  = 4'd10;

    typedef logic [9:0] cm_t;
    typedef logic [3:0] digit_code_t;
    typedef logic [6:0] segment_t;

    typedef enum logic [2:0] {
        PH_TRIG_LOW  = 3'd0,
        PH_TRIG_HIGH = 3'd1,
        PH_WAIT_RISE = 3'd2,
        PH_MEASURE   = 3'd3,
        PH_DISPLAY   = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_LOW_TICKS  = 3'd0,
        CFG_TRIGGER_HIGH_TICKS = 3'd1,
        CFG_ECHO_TIMEOUT_TICKS = 3'd2,
        CFG_TICKS_PER_CM       = 3'd3,
        CFG_MIN_CM             = 3'd4,
        CFG_MAX_CM             = 3'd5,
        CFG_DIGIT_HOLD_TICKS   = 3'd6,
        CFG_REFRESH_ROUNDS     = 3'd7
    } cfg_index_t;

    // Segment a is bit 0, segment g is bit 6; code ten is the dash.
    function automatic segment_t seg_pattern(input digit_code_t code);
        segment_t p;
        case (code)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            4'd10:   p = 7'h40;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

FILE: src/urss_if.sv
// Channel interfaces of the ultrasonic range display unit: tick input, result and configuration.
interface urss_in_if;
    import urss_pkg::*;
    logic valid;
    logic ready;
    logic echo_level;
    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface urss_out_if;
    import urss_pkg::*;
    logic        valid;
    logic        ready;
    logic        trigger_out;
    segment_t    segment_bits;
    logic [3:0]  digit_select_n;
    cm_t         distance_cm;
    logic        measure_done;
    modport source (output valid, output trigger_out, output segment_bits,
                    output digit_select_n, output distance_cm, output measure_done,
                    input ready);
    modport sink   (input valid, input trigger_out, input segment_bits,
                    input digit_select_n, input distance_cm, input measure_done,
                    output ready);
endinterface

interface urss_cfg_if;
    import urss_pkg::*;
    logic                 valid;
    logic                 ready;
    cfg_index_t           index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/ultrasonic_range_to_seven_segment_unit.sv
// Ultrasonic range meter with a multiplexed seven-segment display, top level.
//
// Each request on din is one timer tick with the sampled echo level, and each
// tick produces exactly one result on dout. The unit accepts one tick per clock
// cycle when no result waits or dout is ready; the result is registered on
// acceptance, and a new tick is taken in the same cycle that a waiting result
// is taken. All phase counters, the centimetre sub-counter and the decimal
// split of a latched distance update on acceptance. The sequence is: trigger low,
// trigger high, wait for the echo to rise (timeout latches 999), count echo-high
// ticks, then show four dashes or the decimal digits for refresh_rounds display
// rounds. Configuration writes are always ready and take effect on the next tick.
module ultrasonic_range_to_seven_segment_unit (
    input  logic        clk,
    input  logic        rst_n,
    urss_cfg_if.sink    cfg,
    urss_in_if.sink     din,
    urss_out_if.source  dout
);
    import urss_pkg::*;

    localparam int SEL_W = (DIGITS < 4) ? DIGITS : 4;
    localparam logic [DIGITS-1:0] SEL_LSB = {{(DIGITS-1){1'b0}}, 1'b1};
    localparam logic [POS_W-1:0]  LAST_POS = POS_W'(DIGITS - 1);

    typedef logic [DIGITS-1:0][3:0] codes_t;

    // A programmed count of zero behaves as one.
    function automatic logic [23:0] at_least_one(input logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    // Exact quotient by ten for values below 1029.
    function automatic cm_t div10(input cm_t v);
        logic [20:0] p;
        p = {11'd0, v} * 21'd205;
        return p[20:11];
    endfunction

    function automatic codes_t make_codes(input cm_t d, input cm_t lo, input cm_t hi);
        codes_t c;
        cm_t    v;
        cm_t    q;
        cm_t    rem;
        v = d;
        for (int r = 0; r < DIGITS; r++)
        begin
            if (d < lo || d > hi)
            begin
                c[r] = DASH_CODE;
            end
            else
            begin
                q    = div10(v);
                rem  = v - cm_t'(q * 10);
                c[r] = rem[3:0];
                v    = q;
            end
        end
        return c;
    endfunction

    // Configuration registers.
    logic [7:0]  trig_low_reg;
    logic [7:0]  trig_high_reg;
    logic [15:0] timeout_reg;
    logic [15:0] ticks_per_cm_reg;
    cm_t         min_cm_reg;
    cm_t         max_cm_reg;
    logic [23:0] hold_reg;
    logic [7:0]  rounds_reg;

    // Measurement and display state.
    phase_t            phase_reg, phase_next;
    logic [23:0]       ticks_reg, ticks_next;
    logic [15:0]       echo_ticks_reg, echo_ticks_next;
    logic [15:0]       subcount_reg, subcount_next;
    cm_t               cm_count_reg, cm_count_next;
    codes_t            codes_reg, codes_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        round_reg, round_next;
    segment_t          seg_reg, seg_next;
    logic [DIGITS-1:0] select_reg, select_next;
    cm_t               dist_reg, dist_next;

    // Result register flags.
    logic out_valid_reg, out_valid_next;
    logic trig_reg, trig_next;
    logic done_reg, done_next;

    logic in_ready;
    logic accept;

    assign in_ready  = !out_valid_reg || dout.ready;
    assign accept    = din.valid && in_ready;
    assign din.ready = in_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg     <= 8'd4;
            trig_high_reg    <= 8'd20;
            timeout_reg      <= 16'd60000;
            ticks_per_cm_reg <= 16'd116;
            min_cm_reg       <= 10'd5;
            max_cm_reg       <= 10'd50;
            hold_reg         <= 24'd10000;
            rounds_reg       <= 8'd10;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TRIGGER_LOW_TICKS:  trig_low_reg     <= cfg.data[7:0];
                CFG_TRIGGER_HIGH_TICKS: trig_high_reg    <= cfg.data[7:0];
                CFG_ECHO_TIMEOUT_TICKS: timeout_reg      <= cfg.data[15:0];
                CFG_TICKS_PER_CM:       ticks_per_cm_reg <= cfg.data[15:0];
                CFG_MIN_CM:             min_cm_reg       <= cfg.data[9:0];
                CFG_MAX_CM:             max_cm_reg       <= cfg.data[9:0];
                CFG_DIGIT_HOLD_TICKS:   hold_reg         <= cfg.data[23:0];
                CFG_REFRESH_ROUNDS:     rounds_reg       <= cfg.data[7:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        logic [24:0] ticks_inc;
        logic [15:0] base_echo;
        logic [15:0] base_sub;
        cm_t         base_cm;
        logic [15:0] sub_inc;
        logic [7:0]  round_inc;
        logic        latch;
        cm_t         latch_value;

        phase_next      = phase_reg;
        ticks_next      = ticks_reg;
        echo_ticks_next = echo_ticks_reg;
        subcount_next   = subcount_reg;
        cm_count_next   = cm_count_reg;
        codes_next      = codes_reg;
        pos_next        = pos_reg;
        round_next      = round_reg;
        seg_next        = seg_reg;
        select_next     = select_reg;
        dist_next       = dist_reg;
        trig_next       = 1'b0;
        done_next       = 1'b0;
        latch           = 1'b0;
        latch_value     = cm_count_reg;
        round_inc       = round_reg + 8'd1;
        ticks_inc       = {1'b0, ticks_reg} + 25'd1;

        // The rise tick counts from cleared counters; later ticks extend them.
        if (phase_reg == PH_WAIT_RISE)
        begin
            base_echo = 16'd0;
            base_sub  = 16'd0;
            base_cm   = 10'd0;
        end
        else
        begin
            base_echo = echo_ticks_reg;
            base_sub  = subcount_reg;
            base_cm   = cm_count_reg;
        end
        sub_inc = base_sub + 16'd1;

        unique case (phase_reg) inside
            PH_TRIG_HIGH:
            begin
                trig_next = 1'b1;
                if (ticks_inc >= {1'b0, at_least_one({16'd0, trig_high_reg})})
                begin
                    phase_next = PH_WAIT_RISE;
                    ticks_next = 24'd0;
                end
                else
                begin
                    ticks_next = ticks_inc[23:0];
                end
            end
            PH_WAIT_RISE, PH_MEASURE:
            begin
                if (din.echo_level && (phase_reg == PH_WAIT_RISE ||
                    {8'd0, echo_ticks_reg} < at_least_one({8'd0, timeout_reg})))
                begin
                    phase_next      = PH_MEASURE;
                    echo_ticks_next = base_echo + 16'd1;
                    if ({8'd0, sub_inc} >= at_least_one({8'd0, ticks_per_cm_reg}))
                    begin
                        subcount_next = 16'd0;
                        cm_count_next = (base_cm < NO_ECHO_CM) ? base_cm + 10'd1 : base_cm;
                    end
                    else
                    begin
                        subcount_next = sub_inc;
                        cm_count_next = base_cm;
                    end
                end
                else if (phase_reg == PH_MEASURE)
                begin
                    latch       = 1'b1;
                    latch_value = cm_count_reg;
                end
                else
                begin
                    ticks_next = ticks_inc[23:0];
                    if (ticks_inc >= {1'b0, at_least_one({8'd0, timeout_reg})})
                    begin
                        latch       = 1'b1;
                        latch_value = NO_ECHO_CM;
                    end
                end
            end
            PH_DISPLAY:
            begin
                if (ticks_reg == 24'd0)
                begin
                    seg_next    = seg_pattern(codes_reg[pos_reg]);
                    select_next = ~(SEL_LSB << pos_reg);
                end
                if (ticks_inc >= {1'b0, at_least_one(hold_reg)})
                begin
                    ticks_next = 24'd0;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next = '0;
                        if ({16'd0, round_inc} >= at_least_one({16'd0, rounds_reg}))
                        begin
                            round_next = 8'd0;
                            phase_next = PH_TRIG_LOW;
                        end
                        else
                        begin
                            round_next = round_inc;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                else
                begin
                    ticks_next = ticks_inc[23:0];
                end
            end
            default:
            begin
                // Trigger low, and any unused phase code restarted as trigger low.
                if (phase_reg != PH_TRIG_LOW)
                begin
                    ticks_inc = 25'd1;
                end
                if (ticks_inc >= {1'b0, at_least_one({16'd0, trig_low_reg})})
                begin
                    phase_next = PH_TRIG_HIGH;
                    ticks_next = 24'd0;
                end
                else
                begin
                    phase_next = PH_TRIG_LOW;
                    ticks_next = ticks_inc[23:0];
                end
            end
        endcase

        if (latch)
        begin
            done_next  = 1'b1;
            dist_next  = latch_value;
            codes_next = make_codes(latch_value, min_cm_reg, max_cm_reg);
            phase_next = PH_DISPLAY;
            ticks_next = 24'd0;
            pos_next   = '0;
            round_next = 8'd0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TRIG_LOW;
            ticks_reg      <= 24'd0;
            echo_ticks_reg <= 16'd0;
            subcount_reg   <= 16'd0;
            cm_count_reg   <= 10'd0;
            codes_reg      <= '0;
            pos_reg        <= '0;
            round_reg      <= 8'd0;
            seg_reg        <= 7'd0;
            select_reg     <= '1;
            dist_reg       <= 10'd0;
            out_valid_reg  <= 1'b0;
            trig_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                ticks_reg      <= ticks_next;
                echo_ticks_reg <= echo_ticks_next;
                subcount_reg   <= subcount_next;
                cm_count_reg   <= cm_count_next;
                codes_reg      <= codes_next;
                pos_reg        <= pos_next;
                round_reg      <= round_next;
                seg_reg        <= seg_next;
                select_reg     <= select_next;
                dist_reg       <= dist_next;
                trig_reg       <= trig_next;
                done_reg       <= done_next;
            end
        end
    end

    // The display and distance registers change only on acceptance, so they
    // double as the result payload.
    assign dout.valid          = out_valid_reg;
    assign dout.trigger_out    = trig_reg;
    assign dout.segment_bits   = seg_reg;
    assign dout.digit_select_n = 4'(select_reg[SEL_W-1:0]);
    assign dout.distance_cm    = dist_reg;
    assign dout.measure_done   = done_reg;

    a_trigger_from_high_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_TRIG_HIGH |=> dout.valid && dout.trigger_out)
        else $error("trigger result missing after a trigger-high tick");

    a_select_one_cold: assert property (@(posedge clk) disable iff (!rst_n)
        select_reg == '1 || $countones(~select_reg) == 1)
        else $error("more than one digit selected");

    a_cm_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        cm_count_reg <= NO_ECHO_CM && dist_reg <= NO_ECHO_CM)
        else $error("distance beyond saturation limit");

    a_done_latches_display: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done_next |=> phase_reg == PH_DISPLAY && dout.measure_done)
        else $error("latched distance did not enter the display phase");

endmodule
